[hdl/iwa_pkg.sv]
package iwa_pkg;

    localparam int WORD_W = 32;
    localparam int POS_W  = 16;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;
    // index field width that covers the largest supported depth, plus one for the count
    localparam int IDX_W  = 13;

    localparam logic [OP_W-1:0] OP_READ   = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_RESIZE = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD   = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

    typedef enum logic [2:0] {
        CC_HOLD,
        CC_WRITE,
        CC_INSERT,
        CC_DELETE,
        CC_FILL
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t          cmd;
        logic               rd;
        logic [IDX_W-1:0]   sel;
        logic [IDX_W-1:0]   hi;
        logic [WORD_W-1:0]  data;
    } cell_ctrl_t;

endpackage

[hdl/iwa_cell.sv]
module iwa_cell
    import iwa_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic [WORD_W-1:0]  left,
    input  logic [WORD_W-1:0]  right,
    output logic [WORD_W-1:0]  value,
    output logic [WORD_W-1:0]  rd
);

    localparam logic [IDX_W-1:0] ME = IDX_W'(IDX);

    logic [WORD_W-1:0] value_reg;
    logic [WORD_W-1:0] value_next;
    logic [WORD_W-1:0] rd_reg;
    logic [WORD_W-1:0] rd_next;

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.cmd)
            CC_WRITE:
            begin
                if (ME == ctrl.sel)
                begin
                    value_next = ctrl.data;
                end
            end
            CC_INSERT:
            begin
                if (ME > ctrl.sel)
                begin
                    value_next = left;
                end
                else if (ME == ctrl.sel)
                begin
                    value_next = ctrl.data;
                end
            end
            CC_DELETE:
            begin
                if (ME >= ctrl.sel)
                begin
                    value_next = right;
                end
            end
            CC_FILL:
            begin
                if (ME >= ctrl.sel && ME < ctrl.hi)
                begin
                    value_next = '0;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
        rd_next = (ctrl.rd && ME == ctrl.sel) ? value_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= rd_next;
    end

    assign value = value_reg;
    assign rd    = rd_reg;

endmodule

[hdl/insertable_word_array.sv]
// insertable_word_array: ordered array of signed 32-bit words with a length of
// at most DEPTH entries, one word per cell in a chain of cells.
// Command channel: op, pos, data and new_length are taken at a rising edge
// where start is high and busy is low. busy is high for the one execute cycle.
// Result channel: read_value, length and status are valid for exactly one
// cycle while done is high; the receiver cannot hold results off.
// After the accepting edge a command passes the execute state, then the done state.
// A new command may be accepted in the same cycle that done is high, but not
// while one executes. Every command takes the same time, since
// insert and delete shift all cells in parallel in the execute cycle.
// The read word is gathered from the cells by a wide OR of their read regs.
// Reset: length goes to 0, all cells to zero, no result is pending.
// Ops: 0 read, 1 write, 2 insert, 3 delete, 4 resize; positions clamp for
// read, write and insert. Status: 0 ok, 1 bad position/length, 2 full, 3 empty.
module insertable_word_array
    import iwa_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [OP_W-1:0]                op,
    input  logic signed [POS_W-1:0]        pos,
    input  logic signed [WORD_W-1:0]       data,
    input  logic signed [POS_W-1:0]        new_length,
    output logic                           done,
    output logic signed [WORD_W-1:0]       read_value,
    output logic [$clog2(DEPTH+1)-1:0]     length,
    output logic [ST_W-1:0]                status
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int EXT_W = POS_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [OP_W-1:0]         op_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [WORD_W-1:0]       data_reg;
    logic [POS_W-1:0]        nlen_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [ST_W-1:0]         status_reg;
    logic [ST_W-1:0]         status_next;

    logic                    accept;
    logic signed [EXT_W-1:0] posx;
    logic signed [EXT_W-1:0] nlx;
    logic signed [EXT_W-1:0] cntx;
    logic signed [EXT_W-1:0] depx;
    logic [CW-1:0]           rw_idx;
    logic [CW-1:0]           ins_idx;
    logic                    empty;
    logic                    full;
    cell_ctrl_t              ctrl;

    logic [WORD_W-1:0]       cell_val [DEPTH];
    logic [WORD_W-1:0]       cell_rd  [DEPTH];
    logic [WORD_W-1:0]       rd_or;

    assign accept = start && !busy;

    assign posx  = {pos_reg[POS_W-1], pos_reg};
    assign nlx   = {nlen_reg[POS_W-1], nlen_reg};
    assign cntx  = EXT_W'(count_reg);
    assign depx  = EXT_W'(DEPTH);
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));

    always_comb
    begin
        if (posx < 0)
        begin
            rw_idx  = '0;
        end
        else if (posx >= cntx)
        begin
            rw_idx  = count_reg - 1'b1;
        end
        else
        begin
            rw_idx  = pos_reg[CW-1:0];
        end

        if (posx < 0)
        begin
            ins_idx = '0;
        end
        else if (posx > cntx)
        begin
            ins_idx = count_reg;
        end
        else
        begin
            ins_idx = pos_reg[CW-1:0];
        end
    end

    always_comb
    begin
        ctrl.cmd    = CC_HOLD;
        ctrl.rd     = 1'b0;
        ctrl.sel    = '0;
        ctrl.hi     = '0;
        ctrl.data   = data_reg;
        count_next  = count_reg;
        status_next = status_reg;
        if (state_reg == S_EXEC)
        begin
            status_next = ST_OK;
            case (op_reg)
                OP_READ:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.rd  = 1'b1;
                        ctrl.sel = IDX_W'(rw_idx);
                    end
                end
                OP_WRITE:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.cmd = CC_WRITE;
                        ctrl.sel = IDX_W'(rw_idx);
                    end
                end
                OP_INSERT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.cmd   = CC_INSERT;
                        ctrl.sel   = IDX_W'(ins_idx);
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_DELETE:
                begin
                    if (posx < 0 || posx >= cntx)
                    begin
                        status_next = ST_BAD;
                    end
                    else
                    begin
                        ctrl.cmd   = CC_DELETE;
                        ctrl.sel   = IDX_W'(pos_reg[CW-1:0]);
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_RESIZE:
                begin
                    if (nlx < 0)
                    begin
                        status_next = ST_BAD;
                    end
                    else if (nlx > depx)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.cmd   = CC_FILL;
                        ctrl.sel   = IDX_W'(count_reg);
                        ctrl.hi    = IDX_W'(nlen_reg[CW-1:0]);
                        count_next = nlen_reg[CW-1:0];
                    end
                end
                default:
                begin
                    status_next = ST_BAD;
                end
            endcase
        end
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = accept ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_DONE;
            S_DONE:  state_next = accept ? S_EXEC : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            pos_reg  <= pos;
            data_reg <= data;
            nlen_reg <= new_length;
        end
    end

    // cell chain: each cell sees its lower and upper neighbor
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = cell_val[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = cell_val[i+1];
        end

        iwa_cell #(
            .IDX (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .left  (left_w),
            .right (right_w),
            .value (cell_val[i]),
            .rd    (cell_rd[i])
        );
    end

    // at most one cell holds a nonzero read word
    always_comb
    begin
        rd_or = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            rd_or = rd_or | cell_rd[k];
        end
    end

    assign busy       = (state_reg == S_EXEC);
    assign done       = (state_reg == S_DONE);
    assign read_value = rd_or;
    assign length     = count_reg;
    assign status     = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("length above capacity");

    a_exec_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("execute cycle not followed by result");

    a_count_still: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> $stable(count_reg))
        else $error("length changed outside execute cycle");

    a_fail_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        done && status_reg != ST_OK |-> read_value == '0)
        else $error("read word on refused command");

endmodule
